FILE: hdl/btfa_pkg.sv
// Package for the boundary-tag first-fit allocator core.
// Holds marker layout, request codes, sequencer states and default sizes.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package btfa_pkg;

   // Default store depth in 32-bit words
   localparam int unsigned HEAP_WORDS_DEF = 1024;

   // Marker word layout: bit 31 free flag, bits 30:0 payload size in words
   localparam int unsigned MARK_W   = 32;
   localparam int unsigned SIZE_W   = 31;
   localparam int unsigned FREE_BIT = 31;

   // Field widths of the transaction ports
   localparam int unsigned OP_W     = 2;
   localparam int unsigned BYTES_W  = 16;
   localparam int unsigned OFFS_W   = 10;
   localparam int unsigned STATB_W  = 13;
   // Byte counts keep 13 bits, so word sums keep 11
   localparam int unsigned WORD_SHIFT = 2;
   localparam int unsigned STATW_W  = STATB_W - WORD_SHIFT;
   // Rounded-up word count of a 16-bit byte request
   localparam int unsigned WANT_W   = BYTES_W + 1 - WORD_SHIFT;

   // Request codes
   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_REALLOC = 2'd2,
      OP_STATS   = 2'd3
   } op_type;

   // Response status codes
   localparam logic RSP_OK   = 1'b0;
   localparam logic RSP_FAIL = 1'b1;

   // Purpose of a chain walk
   typedef enum logic [1:0] {
      WALK_ALLOC,
      WALK_CHECK,
      WALK_STATS
   } walk_type;

   // Which marker pair the free sequence is writing
   typedef enum logic [1:0] {
      FPH_OWN,
      FPH_PREV,
      FPH_NEXT
   } fphase_type;

   // Sequencer states
   typedef enum logic [4:0] {
      S_INIT_HEAD,
      S_INIT_TAIL,
      S_IDLE,
      S_REJECT,
      S_WALK,
      S_WALK_EVAL,
      S_CHK_HEAD,
      S_CHK_EVAL,
      S_CHK_TAIL,
      S_ALLOC_HEAD,
      S_ALLOC_TAIL,
      S_SPLIT_HEAD,
      S_SPLIT_TAIL,
      S_FSET_HEAD,
      S_FSET_TAIL,
      S_PREV_RD,
      S_PREV_EVAL,
      S_NEXT_RD,
      S_NEXT_EVAL
   } state_type;

   // End-of-transaction decode
   typedef struct packed {
      logic fin;
      logic fail;
   } finish_type;

endpackage

`default_nettype wire

FILE: hdl/btfa_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Used for the marker store; defaults come from btfa_pkg.
`default_nettype none

module btfa_ram #(
   parameter int unsigned WIDTH = btfa_pkg::MARK_W,
   parameter int unsigned DEPTH = btfa_pkg::HEAP_WORDS_DEF,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read-first port: one access per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/boundary_tag_first_fit_allocator_core.sv
// Top level of the boundary-tag first-fit allocator: sequencer and datapath.
// Depends on btfa_pkg and btfa_ram (marker store).
//
//   Channel   Ports                                    Handshake
//   request   req_op, req_request_bytes, req_block_offset  start & !busy
//   response  rsp_status, rsp_result_offset, rsp_*_bytes   rsp_valid, one cycle
//
// Each transaction walks the block chain, with one RAM read and its
// evaluation per block visited (S_WALK, S_WALK_EVAL), then reads and writes
// markers where it changes the store; a reallocate walks twice, a bad
// offset is rejected without a walk. The single store port allows one
// marker read or write per cycle. After reset the store is formatted
// (S_INIT_HEAD, S_INIT_TAIL) with busy high. The response strobe cannot
// be held off; a new request may start in the cycle the response is shown.
`default_nettype none

module boundary_tag_first_fit_allocator_core #(
   parameter int unsigned HEAP_WORDS = btfa_pkg::HEAP_WORDS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [btfa_pkg::OP_W-1:0]     req_op,
   input  wire logic [btfa_pkg::BYTES_W-1:0]  req_request_bytes,
   input  wire logic [btfa_pkg::OFFS_W-1:0]   req_block_offset,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic [btfa_pkg::OFFS_W-1:0]        rsp_result_offset,
   output logic [btfa_pkg::STATB_W-1:0]       rsp_used_bytes,
   output logic [btfa_pkg::STATB_W-1:0]       rsp_free_bytes,
   output logic [btfa_pkg::STATB_W-1:0]       rsp_total_bytes
);

   localparam int unsigned AW = $clog2(HEAP_WORDS);
   localparam int unsigned PW = AW + 1;

   // Marker of the single free block after formatting
   localparam logic [btfa_pkg::MARK_W-1:0] INIT_MARK =
      {1'b1, btfa_pkg::SIZE_W'(HEAP_WORDS - 2)};

   // Block of size s headed at h ends inside the store
   function automatic logic fits_at(input logic [31:0] head,
                                    input logic [btfa_pkg::SIZE_W-1:0] size);
      logic [32:0] last;
      last = 33'(head) + 33'(size) + 33'd1;
      return last < 33'(HEAP_WORDS);
   endfunction

   // Control and payload registers
   btfa_pkg::state_type  state_ff, state_in;
   btfa_pkg::op_type     op_ff, op_in;
   btfa_pkg::walk_type   mode_ff, mode_in;
   btfa_pkg::fphase_type fph_ff, fph_in;
   logic [PW-1:0]                   p_ff, p_in;
   logic [btfa_pkg::WANT_W-1:0]     want_ff, want_in;
   logic [AW-1:0]                   ah_ff, ah_in;
   logic [AW-1:0]                   as_ff, as_in;
   logic [AW-1:0]                   fh_ff, fh_in;
   logic [AW-1:0]                   fs_ff, fs_in;
   logic [btfa_pkg::MARK_W-1:0]     head_ff, head_in;
   logic [btfa_pkg::STATW_W-1:0]    usedw_ff, usedw_in;
   logic [btfa_pkg::STATW_W-1:0]    freew_ff, freew_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_status_ff, rsp_status_in;
   logic [btfa_pkg::OFFS_W-1:0]     rsp_offs_ff, rsp_offs_in;
   logic [btfa_pkg::STATB_W-1:0]    rsp_used_ff, rsp_used_in;
   logic [btfa_pkg::STATB_W-1:0]    rsp_free_ff, rsp_free_in;
   logic [btfa_pkg::STATB_W-1:0]    rsp_total_ff, rsp_total_in;

   // Store port
   logic                          ram_we;
   logic [AW-1:0]                 ram_addr;
   logic [btfa_pkg::MARK_W-1:0]   ram_wdata;
   logic [btfa_pkg::MARK_W-1:0]   ram_rdata;

   // Decoded conditions
   logic                          accept;
   logic                          bad_ptr;
   logic [btfa_pkg::SIZE_W-1:0]   rd_size;
   logic                          rd_free;
   logic                          walk_end;
   logic                          walk_fit;
   logic                          alloc_hit;
   logic                          chk_fit;
   logic                          split;
   logic [AW-1:0]                 hsz;
   logic [31:0]                   nx32;
   logic                          nx_in;
   logic                          prev_ok;
   logic                          next_ok;
   logic [PW-1:0]                 p_step;
   btfa_pkg::finish_type          fin;

   btfa_ram #(
      .WIDTH (btfa_pkg::MARK_W),
      .DEPTH (HEAP_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign busy    = (state_ff != btfa_pkg::S_IDLE);
   assign accept  = start && !busy;
   assign bad_ptr = (req_block_offset == '0) ||
                    (32'(req_block_offset) >= 32'(HEAP_WORDS));

   // Marker evaluation
   assign rd_size   = ram_rdata[btfa_pkg::SIZE_W-1:0];
   assign rd_free   = ram_rdata[btfa_pkg::FREE_BIT];
   assign walk_end  = (32'(p_ff) >= 32'(HEAP_WORDS));
   assign walk_fit  = fits_at(32'(p_ff), rd_size);
   assign alloc_hit = rd_free && (32'(want_ff) <= 32'(rd_size));
   assign chk_fit   = fits_at(32'(fh_ff), rd_size);
   assign p_step    = PW'(32'(p_ff) + 32'(rd_size) + 32'd2);
   assign split     = (32'(as_ff) - 32'(want_ff)) >= 32'd2;
   assign hsz       = split ? AW'(want_ff) : as_ff;
   assign nx32      = 32'(fh_ff) + 32'(fs_ff) + 32'd2;
   assign nx_in     = nx32 < 32'(HEAP_WORDS);
   assign prev_ok   = rd_free && (33'(fh_ff) >= (33'(rd_size) + 33'd2));
   assign next_ok   = rd_free && fits_at(nx32, rd_size);

   // End of transaction decode
   always_comb begin
      fin = '0;
      unique case (state_ff)
         btfa_pkg::S_REJECT: begin
            fin = '{fin: 1'b1, fail: 1'b1};
         end
         btfa_pkg::S_WALK: begin
            if (walk_end) begin
               fin = '{fin: 1'b1, fail: (mode_ff != btfa_pkg::WALK_STATS)};
            end
         end
         btfa_pkg::S_WALK_EVAL: begin
            if (!walk_fit) begin
               fin = '{fin: 1'b1, fail: (mode_ff != btfa_pkg::WALK_STATS)};
            end
         end
         btfa_pkg::S_CHK_EVAL: begin
            if (rd_free || !chk_fit) begin
               fin = '{fin: 1'b1, fail: 1'b1};
            end
         end
         btfa_pkg::S_CHK_TAIL: begin
            if (ram_rdata != head_ff) begin
               fin = '{fin: 1'b1, fail: 1'b1};
            end
         end
         btfa_pkg::S_ALLOC_TAIL: begin
            if (!split && (op_ff != btfa_pkg::OP_REALLOC)) begin
               fin = '{fin: 1'b1, fail: 1'b0};
            end
         end
         btfa_pkg::S_SPLIT_TAIL: begin
            if (op_ff != btfa_pkg::OP_REALLOC) begin
               fin = '{fin: 1'b1, fail: 1'b0};
            end
         end
         btfa_pkg::S_FSET_TAIL: begin
            if (fph_ff == btfa_pkg::FPH_NEXT) begin
               fin = '{fin: 1'b1, fail: 1'b0};
            end
         end
         btfa_pkg::S_NEXT_RD: begin
            if (!nx_in) begin
               fin = '{fin: 1'b1, fail: 1'b0};
            end
         end
         btfa_pkg::S_NEXT_EVAL: begin
            if (!next_ok) begin
               fin = '{fin: 1'b1, fail: 1'b0};
            end
         end
         default: begin
            fin = '0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      if (fin.fin) begin
         state_in = btfa_pkg::S_IDLE;
      end else begin
         unique case (state_ff)
            btfa_pkg::S_INIT_HEAD: state_in = btfa_pkg::S_INIT_TAIL;
            btfa_pkg::S_INIT_TAIL: state_in = btfa_pkg::S_IDLE;
            btfa_pkg::S_IDLE: begin
               if (accept) begin
                  if (((req_op == btfa_pkg::OP_FREE) || (req_op == btfa_pkg::OP_REALLOC))
                      && bad_ptr) begin
                     state_in = btfa_pkg::S_REJECT;
                  end else begin
                     state_in = btfa_pkg::S_WALK;
                  end
               end
            end
            btfa_pkg::S_WALK: begin
               if ((mode_ff == btfa_pkg::WALK_CHECK) && (p_ff == PW'(fh_ff))) begin
                  state_in = btfa_pkg::S_CHK_HEAD;
               end else begin
                  state_in = btfa_pkg::S_WALK_EVAL;
               end
            end
            btfa_pkg::S_WALK_EVAL: begin
               if ((mode_ff == btfa_pkg::WALK_ALLOC) && alloc_hit) begin
                  state_in = btfa_pkg::S_ALLOC_HEAD;
               end else begin
                  state_in = btfa_pkg::S_WALK;
               end
            end
            btfa_pkg::S_CHK_HEAD: state_in = btfa_pkg::S_CHK_EVAL;
            btfa_pkg::S_CHK_EVAL: state_in = btfa_pkg::S_CHK_TAIL;
            btfa_pkg::S_CHK_TAIL: begin
               if (op_ff == btfa_pkg::OP_REALLOC) begin
                  state_in = btfa_pkg::S_WALK;
               end else begin
                  state_in = btfa_pkg::S_FSET_HEAD;
               end
            end
            btfa_pkg::S_ALLOC_HEAD: state_in = btfa_pkg::S_ALLOC_TAIL;
            btfa_pkg::S_ALLOC_TAIL: begin
               if (split) begin
                  state_in = btfa_pkg::S_SPLIT_HEAD;
               end else begin
                  state_in = btfa_pkg::S_FSET_HEAD;
               end
            end
            btfa_pkg::S_SPLIT_HEAD: state_in = btfa_pkg::S_SPLIT_TAIL;
            btfa_pkg::S_SPLIT_TAIL: state_in = btfa_pkg::S_FSET_HEAD;
            btfa_pkg::S_FSET_HEAD:  state_in = btfa_pkg::S_FSET_TAIL;
            btfa_pkg::S_FSET_TAIL: begin
               if ((fph_ff == btfa_pkg::FPH_OWN) && (fh_ff != '0)) begin
                  state_in = btfa_pkg::S_PREV_RD;
               end else begin
                  state_in = btfa_pkg::S_NEXT_RD;
               end
            end
            btfa_pkg::S_PREV_RD: state_in = btfa_pkg::S_PREV_EVAL;
            btfa_pkg::S_PREV_EVAL: begin
               if (prev_ok) begin
                  state_in = btfa_pkg::S_FSET_HEAD;
               end else begin
                  state_in = btfa_pkg::S_NEXT_RD;
               end
            end
            btfa_pkg::S_NEXT_RD:   state_in = btfa_pkg::S_NEXT_EVAL;
            btfa_pkg::S_NEXT_EVAL: state_in = btfa_pkg::S_FSET_HEAD;
            default:               state_in = btfa_pkg::S_IDLE;
         endcase
      end
   end

   // Datapath, store port and response
   always_comb begin
      op_in     = op_ff;
      mode_in   = mode_ff;
      fph_in    = fph_ff;
      p_in      = p_ff;
      want_in   = want_ff;
      ah_in     = ah_ff;
      as_in     = as_ff;
      fh_in     = fh_ff;
      fs_in     = fs_ff;
      head_in   = head_ff;
      usedw_in  = usedw_ff;
      freew_in  = freew_ff;
      ram_we    = 1'b0;
      ram_addr  = fh_ff;
      ram_wdata = '0;

      unique case (state_ff)
         btfa_pkg::S_INIT_HEAD: begin
            ram_we    = 1'b1;
            ram_addr  = '0;
            ram_wdata = INIT_MARK;
         end
         btfa_pkg::S_INIT_TAIL: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(HEAP_WORDS - 1);
            ram_wdata = INIT_MARK;
         end
         btfa_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = btfa_pkg::op_type'(req_op);
               want_in  = btfa_pkg::WANT_W'((17'(req_request_bytes) + 17'd3)
                                            >> btfa_pkg::WORD_SHIFT);
               p_in     = '0;
               usedw_in = '0;
               freew_in = '0;
               fph_in   = btfa_pkg::FPH_OWN;
               fh_in    = AW'(req_block_offset - btfa_pkg::OFFS_W'(1));
               unique case (btfa_pkg::op_type'(req_op))
                  btfa_pkg::OP_ALLOC: mode_in = btfa_pkg::WALK_ALLOC;
                  btfa_pkg::OP_STATS: mode_in = btfa_pkg::WALK_STATS;
                  default:            mode_in = btfa_pkg::WALK_CHECK;
               endcase
            end
         end
         btfa_pkg::S_WALK: begin
            ram_addr = AW'(p_ff);
         end
         btfa_pkg::S_WALK_EVAL: begin
            if (walk_fit) begin
               unique case (mode_ff)
                  btfa_pkg::WALK_ALLOC: begin
                     if (alloc_hit) begin
                        ah_in = AW'(p_ff);
                        as_in = AW'(rd_size);
                     end else begin
                        p_in = p_step;
                     end
                  end
                  btfa_pkg::WALK_STATS: begin
                     if (rd_free) begin
                        freew_in = freew_ff + rd_size[btfa_pkg::STATW_W-1:0];
                     end else begin
                        usedw_in = usedw_ff + rd_size[btfa_pkg::STATW_W-1:0];
                     end
                     p_in = p_step;
                  end
                  default: begin
                     p_in = p_step;
                  end
               endcase
            end
         end
         btfa_pkg::S_CHK_HEAD: begin
            ram_addr = fh_ff;
         end
         btfa_pkg::S_CHK_EVAL: begin
            // Keep the head marker and fetch the tail
            head_in  = ram_rdata;
            fs_in    = AW'(rd_size);
            ram_addr = AW'(32'(fh_ff) + 32'(rd_size) + 32'd1);
         end
         btfa_pkg::S_CHK_TAIL: begin
            // Reallocate: old block is sound, now look for the new one
            p_in    = '0;
            mode_in = btfa_pkg::WALK_ALLOC;
         end
         btfa_pkg::S_ALLOC_HEAD: begin
            ram_we    = 1'b1;
            ram_addr  = ah_ff;
            ram_wdata = {1'b0, btfa_pkg::SIZE_W'(hsz)};
         end
         btfa_pkg::S_ALLOC_TAIL: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(32'(ah_ff) + 32'(hsz) + 32'd1);
            ram_wdata = {1'b0, btfa_pkg::SIZE_W'(hsz)};
         end
         btfa_pkg::S_SPLIT_HEAD: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(32'(ah_ff) + 32'(want_ff) + 32'd2);
            ram_wdata = {1'b1, btfa_pkg::SIZE_W'(32'(as_ff) - 32'(want_ff) - 32'd2)};
         end
         btfa_pkg::S_SPLIT_TAIL: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(32'(ah_ff) + 32'(as_ff) + 32'd1);
            ram_wdata = {1'b1, btfa_pkg::SIZE_W'(32'(as_ff) - 32'(want_ff) - 32'd2)};
         end
         btfa_pkg::S_FSET_HEAD: begin
            ram_we    = 1'b1;
            ram_addr  = fh_ff;
            ram_wdata = {1'b1, btfa_pkg::SIZE_W'(fs_ff)};
         end
         btfa_pkg::S_FSET_TAIL: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(32'(fh_ff) + 32'(fs_ff) + 32'd1);
            ram_wdata = {1'b1, btfa_pkg::SIZE_W'(fs_ff)};
         end
         btfa_pkg::S_PREV_RD: begin
            ram_addr = AW'(fh_ff - AW'(1));
         end
         btfa_pkg::S_PREV_EVAL: begin
            // Merge with the free block below
            if (prev_ok) begin
               fh_in  = AW'(33'(fh_ff) - 33'(rd_size) - 33'd2);
               fs_in  = AW'(32'(rd_size) + 32'(fs_ff) + 32'd2);
               fph_in = btfa_pkg::FPH_PREV;
            end
         end
         btfa_pkg::S_NEXT_RD: begin
            ram_addr = AW'(nx32);
         end
         btfa_pkg::S_NEXT_EVAL: begin
            // Merge with the free block above
            if (next_ok) begin
               fs_in  = AW'(32'(fs_ff) + 32'(rd_size) + 32'd2);
               fph_in = btfa_pkg::FPH_NEXT;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Response register loads
   always_comb begin
      rsp_valid_in  = fin.fin;
      rsp_status_in = rsp_status_ff;
      rsp_offs_in   = rsp_offs_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_total_in  = rsp_total_ff;
      if (fin.fin) begin
         rsp_status_in = fin.fail ? btfa_pkg::RSP_FAIL : btfa_pkg::RSP_OK;
         rsp_offs_in   = '0;
         rsp_used_in   = '0;
         rsp_free_in   = '0;
         rsp_total_in  = '0;
         if (!fin.fail && ((op_ff == btfa_pkg::OP_ALLOC) ||
                           (op_ff == btfa_pkg::OP_REALLOC))) begin
            rsp_offs_in = btfa_pkg::OFFS_W'(32'(ah_ff) + 32'd1);
         end
         if (op_ff == btfa_pkg::OP_STATS) begin
            rsp_used_in  = {usedw_ff, btfa_pkg::WORD_SHIFT'(0)};
            rsp_free_in  = {freew_ff, btfa_pkg::WORD_SHIFT'(0)};
            rsp_total_in = {btfa_pkg::STATW_W'(usedw_ff + freew_ff),
                            btfa_pkg::WORD_SHIFT'(0)};
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btfa_pkg::S_INIT_HEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      mode_ff       <= mode_in;
      fph_ff        <= fph_in;
      p_ff          <= p_in;
      want_ff       <= want_in;
      ah_ff         <= ah_in;
      as_ff         <= as_in;
      fh_ff         <= fh_in;
      fs_ff         <= fs_in;
      head_ff       <= head_in;
      usedw_ff      <= usedw_in;
      freew_ff      <= freew_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offs_ff   <= rsp_offs_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_offset = rsp_offs_ff;
   assign rsp_used_bytes    = rsp_used_ff;
   assign rsp_free_bytes    = rsp_free_ff;
   assign rsp_total_bytes   = rsp_total_ff;

`ifndef SYNTH
   // Every accepted transaction sets busy: the sequencer leaves S_IDLE on accepting it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("sequencer idle right after accepting a transaction");

   // The store is only written while a transaction or formatting runs
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btfa_pkg::S_IDLE) |-> !ram_we)
      else $error("store written while idle");

   // A response is shown only if the sequencer was busy in the cycle before
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a transaction in progress");

   // Chain walk never runs past the end of the store
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btfa_pkg::S_WALK) |-> (32'(p_ff) <= 32'(HEAP_WORDS)))
      else $error("walk pointer beyond store");
`endif

endmodule

`default_nettype wire
